@@ hw/rtl/arsc_pkg.sv @@
// Shared constants, types and state encodings of the audio resample slice scale block.
`timescale 1ns / 1ps

package arsc_pkg;

    // Fixed-point formats
    localparam int PHASE_FRAC_BITS = 16;
    localparam int SAMPLE_BITS     = 16;
    localparam int MAX_OUTPUTS     = 16;

    // Register widths
    localparam int STEP_W  = PHASE_FRAC_BITS + 3;
    localparam int THR_W   = 15;
    localparam int CLIP_W  = 15;
    localparam int BOOST_W = 7;
    localparam int FMT_W   = 2;
    localparam int OUT_W   = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = STEP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEVEL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FORMAT   = 3'd4;

    // Output format codes
    localparam logic [FMT_W-1:0] FMT_INT16  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_UINT8  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_INT32  = 2'd2;

    // Register reset values
    localparam logic [STEP_W-1:0]  RST_PHASE_STEP      = STEP_W'(40960);
    localparam logic [THR_W-1:0]   RST_SLICE_THRESHOLD = '0;
    localparam logic [CLIP_W-1:0]  RST_CLIP_LEVEL      = CLIP_W'(6000);
    localparam logic [BOOST_W-1:0] RST_BOOST           = BOOST_W'(10);
    localparam logic [FMT_W-1:0]   RST_OUTPUT_FORMAT   = FMT_INT16;

    // Datapath widths
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int ACC_W  = STEP_W + 1;
    localparam int PROD_W = SAMPLE_BITS + PHASE_FRAC_BITS + 2;
    localparam int DEN_W  = CLIP_W + PHASE_FRAC_BITS;
    localparam int MAG_W  = DEN_W + BOOST_W;

    // Full-scale constants: 32767 = 2^15 - 1, 2^31 - 1, 255 = 2^8 - 1
    localparam int K16_SHIFT = 15;
    localparam int K32_SHIFT = 31;
    localparam int U8_SHIFT  = 8;
    localparam int XW        = MAG_W + K32_SHIFT;
    localparam int NUM_W     = XW - PHASE_FRAC_BITS;

    // Divider: quotient never reaches 2^QUO_W, DIV_STEP bits per cycle
    localparam int QUO_W      = 40;
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = QUO_W / DIV_STEP;

    localparam logic [OUT_W-1:0] INT16_MAX     = OUT_W'(32767);
    localparam logic [OUT_W-1:0] INT16_NEG_LIM = OUT_W'(32768);
    localparam logic [OUT_W-1:0] INT32_MAX     = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] INT32_NEG_LIM = 32'h8000_0000;
    localparam logic [OUT_W-1:0] UINT8_MAX     = OUT_W'(255);

    // Queue depths
    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    typedef struct packed {
        logic [STEP_W-1:0]  phase_step;
        logic [THR_W-1:0]   slice_threshold;
        logic [CLIP_W-1:0]  clip_level;
        logic [BOOST_W-1:0] boost;
        logic [FMT_W-1:0]   output_format;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] cur;
        logic [PHASE_FRAC_BITS-1:0]    acc;
        logic signed [DIFF_W-1:0]      diff;
        logic                          last;
    } t_job;

    typedef struct packed {
        logic [OUT_W-1:0] sample;
        logic             last;
    } t_res;

    typedef enum logic {
        F_IDLE,
        F_EMIT
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SLICE,
        B_CLAMP,
        B_BOOST,
        B_NUMER,
        B_DIV,
        B_PUSH
    } t_back_state;

endpackage

@@ hw/rtl/audio_resample_slice_scale.sv @@
// Top level of the audio resample slice scale block: configuration registers and queues.
`timescale 1ns / 1ps

// Linear-interpolation resampler with a dead-zone slicer and audio scaling.
// Each signed microvolt sample pushed in yields one to MAX_OUTPUTS audio
// samples, popped from the result side in order; o_last marks the final one
// of each input. The front part accepts a sample while idle and then issues
// one interpolation job per cycle into a four-entry job queue while that
// queue has room, so full stays high until the sample's last job is issued.
// For each result the back part takes the job and forms the interpolation
// product, then slices, clamps, boosts and forms the numerator, divides by
// clip_level in the divider (four quotient bits a cycle), and writes the
// four-entry result queue.
// Configuration writes take effect at once and must only be made while the
// block holds no unfinished input.
module audio_resample_slice_scale #(
    parameter int MAX_OUTPUTS = arsc_pkg::MAX_OUTPUTS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     push,
    output logic                                     full,
    input  logic signed [arsc_pkg::SAMPLE_BITS-1:0]  i_sample_in,
    output logic                                     empty,
    input  logic                                     pop,
    output logic signed [arsc_pkg::OUT_W-1:0]        o_sample_out,
    output logic                                     o_last,
    input  logic                                     i_cfg_we,
    input  logic [arsc_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [arsc_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    localparam int JOB_W = $bits(arsc_pkg::t_job);
    localparam int RES_W = $bits(arsc_pkg::t_res);

    arsc_pkg::t_cfg r_cfg;

    logic           job_push;
    logic           job_full;
    logic           job_pop;
    logic           job_empty;
    arsc_pkg::t_job job_in;
    arsc_pkg::t_job job_out;
    logic           res_push;
    logic           res_full;
    arsc_pkg::t_res res_in;
    arsc_pkg::t_res res_out;

    // Configuration registers; writes to unused indexes drop silently
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step      <= arsc_pkg::RST_PHASE_STEP;
            r_cfg.slice_threshold <= arsc_pkg::RST_SLICE_THRESHOLD;
            r_cfg.clip_level      <= arsc_pkg::RST_CLIP_LEVEL;
            r_cfg.boost           <= arsc_pkg::RST_BOOST;
            r_cfg.output_format   <= arsc_pkg::RST_OUTPUT_FORMAT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                arsc_pkg::CFG_PHASE_STEP:
                    r_cfg.phase_step <= i_cfg_data[arsc_pkg::STEP_W-1:0];
                arsc_pkg::CFG_SLICE_THRESHOLD:
                    r_cfg.slice_threshold <= i_cfg_data[arsc_pkg::THR_W-1:0];
                arsc_pkg::CFG_CLIP_LEVEL:
                    r_cfg.clip_level <= i_cfg_data[arsc_pkg::CLIP_W-1:0];
                arsc_pkg::CFG_BOOST:
                    r_cfg.boost <= i_cfg_data[arsc_pkg::BOOST_W-1:0];
                arsc_pkg::CFG_OUTPUT_FORMAT:
                    r_cfg.output_format <= i_cfg_data[arsc_pkg::FMT_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: phase walk, one job per emitted sample
    arsc_front #(
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_sample_in (i_sample_in),
        .o_full      (full),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .i_job_full  (job_full)
    );

    // Job queue decouples the phase walk from the arithmetic
    arsc_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (arsc_pkg::JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    // Back: interpolate, slice, scale, saturate
    arsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_res       (res_in),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    // Result queue holds finished samples until the consumer transfers them
    arsc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (arsc_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_sample_out = $signed(res_out.sample);
    assign o_last       = res_out.last;

endmodule

@@ hw/rtl/arsc_fifo.sv @@
// Small register queue with first-word fall-through read.
`timescale 1ns / 1ps

module arsc_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hw/rtl/arsc_front.sv @@
// Front part: takes samples, walks the phase and issues one interpolation job per cycle while the job queue has room.
`timescale 1ns / 1ps

module arsc_front #(
    parameter int MAX_OUTPUTS = arsc_pkg::MAX_OUTPUTS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  arsc_pkg::t_cfg                         i_cfg,
    input  logic                                   i_push,
    input  logic signed [arsc_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                   o_full,
    output logic                                   o_job_push,
    output arsc_pkg::t_job                         o_job,
    input  logic                                   i_job_full
);

    localparam int F      = arsc_pkg::PHASE_FRAC_BITS;
    localparam int S      = arsc_pkg::SAMPLE_BITS;
    localparam int DIFF_W = arsc_pkg::DIFF_W;
    localparam int ACC_W  = arsc_pkg::ACC_W;
    localparam int CNT_W  = $clog2(MAX_OUTPUTS);

    arsc_pkg::t_front_state r_state;
    arsc_pkg::t_front_state n_state;

    logic signed [S-1:0] r_held;
    logic signed [S-1:0] r_next;
    logic [F-1:0]        r_phase;
    logic [F-1:0]        r_acc;
    logic [CNT_W-1:0]    r_cnt;

    logic [ACC_W-1:0]        acc_sum;
    logic signed [DIFF_W-1:0] diff;
    logic                     last;

    assign acc_sum = ACC_W'(r_acc) + ACC_W'(i_cfg.phase_step);
    assign diff    = DIFF_W'(r_next) - DIFF_W'(r_held);
    // Stop once the phase reaches one, or at the output cap
    assign last    = (acc_sum[ACC_W-1:F] != '0) || (r_cnt == CNT_W'(MAX_OUTPUTS - 1));

    assign o_job.cur  = r_held;
    assign o_job.acc  = r_acc;
    assign o_job.diff = diff;
    assign o_job.last = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arsc_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_full     = 1'b1;
        o_job_push = 1'b0;
        unique case (r_state)
            arsc_pkg::F_IDLE: begin
                o_full = 1'b0;
                if (i_push) begin
                    n_state = arsc_pkg::F_EMIT;
                end
            end
            arsc_pkg::F_EMIT: begin
                if (!i_job_full) begin
                    o_job_push = 1'b1;
                    if (last) begin
                        n_state = arsc_pkg::F_IDLE;
                    end
                end
            end
            default: n_state = arsc_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_phase <= '0;
            r_cnt   <= '0;
        end else begin
            if (r_state == arsc_pkg::F_IDLE && i_push) begin
                r_next <= i_sample_in;
                r_acc  <= r_phase;
                r_cnt  <= '0;
            end
            if (o_job_push) begin
                // Drop the integer part of the phase
                if (last) begin
                    r_phase <= acc_sum[F-1:0];
                    r_held  <= r_next;
                end else begin
                    r_acc <= acc_sum[F-1:0];
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/arsc_back.sv @@
// Back part: interpolates, slices, clamps, boosts and scales one job through a shared divider.
`timescale 1ns / 1ps

module arsc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  arsc_pkg::t_cfg i_cfg,
    input  arsc_pkg::t_job i_job,
    input  logic           i_job_empty,
    output logic           o_job_pop,
    output arsc_pkg::t_res o_res,
    output logic           o_res_push,
    input  logic           i_res_full
);

    localparam int F          = arsc_pkg::PHASE_FRAC_BITS;
    localparam int S          = arsc_pkg::SAMPLE_BITS;
    localparam int PROD_W     = arsc_pkg::PROD_W;
    localparam int DEN_W      = arsc_pkg::DEN_W;
    localparam int MAG_W      = arsc_pkg::MAG_W;
    localparam int CLIP_W     = arsc_pkg::CLIP_W;
    localparam int XW         = arsc_pkg::XW;
    localparam int NUM_W      = arsc_pkg::NUM_W;
    localparam int QUO_W      = arsc_pkg::QUO_W;
    localparam int OUT_W      = arsc_pkg::OUT_W;
    localparam int DIV_STEP   = arsc_pkg::DIV_STEP;
    localparam int DIV_CYCLES = arsc_pkg::DIV_CYCLES;
    localparam int DIVC_W     = $clog2(DIV_CYCLES);
    localparam int NW8        = MAG_W + 2;

    arsc_pkg::t_back_state r_state;
    arsc_pkg::t_back_state n_state;

    logic signed [S-1:0]      r_cur;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_last;
    logic signed [PROD_W-1:0] r_sv;
    logic [DEN_W-1:0]         r_abs;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_zero;
    logic [CLIP_W-1:0]        r_rem;
    logic [QUO_W-1:0]         r_quo;
    logic [DIVC_W-1:0]        r_div_cnt;

    logic [CLIP_W-1:0]        clip_eff;
    logic [DEN_W-1:0]         den;
    logic signed [PROD_W-1:0] prod_in;
    logic signed [PROD_W-1:0] cur_ext;
    logic signed [PROD_W-1:0] v;
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-1:0] sv_in;
    logic                     neg_in;
    logic [PROD_W-1:0]        abs_full;
    logic [DEN_W-1:0]         abs_in;
    logic [MAG_W-1:0]         mag_in;
    logic [XW-1:0]            x16;
    logic [XW-1:0]            x32;
    logic signed [NW8-1:0]    den_s;
    logic signed [NW8-1:0]    mag_s;
    logic signed [NW8-1:0]    n8;
    logic                     n8_pos;
    logic [XW-1:0]            x8;
    logic [NUM_W-1:0]         numer;
    logic                     zero_in;
    logic [CLIP_W:0]          rem_v;
    logic [QUO_W-1:0]         quo_v;
    logic [OUT_W-1:0]         lim;
    logic [OUT_W-1:0]         mag_sat;
    logic [OUT_W-1:0]         res_val;

    // A zero clip level acts as one
    assign clip_eff = (i_cfg.clip_level == '0) ? CLIP_W'(1) : i_cfg.clip_level;
    assign den      = {clip_eff, {F{1'b0}}};

    // Interpolation product, taken from the queue head
    assign prod_in = $signed({1'b0, i_job.acc}) * $signed(i_job.diff);

    // Dead-zone slicer
    assign cur_ext = PROD_W'(r_cur);
    assign v       = (cur_ext <<< F) + r_prod;
    assign t       = $signed(PROD_W'({i_cfg.slice_threshold, {F{1'b0}}}));

    always_comb begin
        if (v > t) begin
            sv_in = v - t;
        end else if (v < -t) begin
            sv_in = v + t;
        end else begin
            sv_in = '0;
        end
    end

    // Clamp to plus or minus full scale, split sign and magnitude
    assign neg_in   = r_sv[PROD_W-1];
    assign abs_full = neg_in ? -r_sv : r_sv;
    assign abs_in   = (abs_full > PROD_W'(den)) ? den : abs_full[DEN_W-1:0];

    assign mag_in = r_abs * i_cfg.boost;

    // Numerators: mag * (2^k - 1) as shift and subtract, for UINT8 (den +/- mag) * (2^8 - 1)
    assign x16    = (XW'(r_mag) << arsc_pkg::K16_SHIFT) - XW'(r_mag);
    assign x32    = (XW'(r_mag) << arsc_pkg::K32_SHIFT) - XW'(r_mag);
    assign den_s  = $signed(NW8'(den));
    assign mag_s  = $signed(NW8'(r_mag));
    assign n8     = r_neg ? (den_s - mag_s) : (den_s + mag_s);
    assign n8_pos = !n8[NW8-1] && (n8 != '0);
    assign x8     = (XW'(n8[NW8-2:0]) << arsc_pkg::U8_SHIFT) - XW'(n8[NW8-2:0]);

    always_comb begin
        numer   = '0;
        zero_in = 1'b0;
        unique case (i_cfg.output_format)
            arsc_pkg::FMT_INT16: numer = NUM_W'(x16 >> F);
            arsc_pkg::FMT_INT32: numer = NUM_W'(x32 >> F);
            arsc_pkg::FMT_UINT8: begin
                numer   = NUM_W'(x8 >> (F + 1));
                zero_in = !n8_pos;
            end
            default: zero_in = 1'b1;
        endcase
    end

    // Restoring divider by the clip level, DIV_STEP quotient bits per cycle
    always_comb begin
        rem_v = {1'b0, r_rem};
        quo_v = r_quo;
        for (int i = 0; i < DIV_STEP; i++) begin
            rem_v = {rem_v[CLIP_W-1:0], quo_v[QUO_W-1]};
            quo_v = {quo_v[QUO_W-2:0], 1'b0};
            if (rem_v >= {1'b0, clip_eff}) begin
                rem_v    = rem_v - {1'b0, clip_eff};
                quo_v[0] = 1'b1;
            end
        end
    end

    // Saturate to the selected format and apply the sign for the signed formats
    always_comb begin
        lim     = '0;
        mag_sat = '0;
        res_val = '0;
        unique case (i_cfg.output_format)
            arsc_pkg::FMT_INT16: begin
                lim     = r_neg ? arsc_pkg::INT16_NEG_LIM : arsc_pkg::INT16_MAX;
                mag_sat = (r_quo > QUO_W'(lim)) ? lim : r_quo[OUT_W-1:0];
                res_val = r_neg ? (~mag_sat + OUT_W'(1)) : mag_sat;
            end
            arsc_pkg::FMT_INT32: begin
                lim     = r_neg ? arsc_pkg::INT32_NEG_LIM : arsc_pkg::INT32_MAX;
                mag_sat = (r_quo > QUO_W'(lim)) ? lim : r_quo[OUT_W-1:0];
                res_val = r_neg ? (~mag_sat + OUT_W'(1)) : mag_sat;
            end
            arsc_pkg::FMT_UINT8: begin
                lim     = arsc_pkg::UINT8_MAX;
                mag_sat = (r_quo > QUO_W'(lim)) ? lim : r_quo[OUT_W-1:0];
                res_val = r_zero ? '0 : mag_sat;
            end
            default: res_val = '0;
        endcase
    end

    assign o_res.sample = res_val;
    assign o_res.last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arsc_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            arsc_pkg::B_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_state   = arsc_pkg::B_SLICE;
                end
            end
            arsc_pkg::B_SLICE: n_state = arsc_pkg::B_CLAMP;
            arsc_pkg::B_CLAMP: n_state = arsc_pkg::B_BOOST;
            arsc_pkg::B_BOOST: n_state = arsc_pkg::B_NUMER;
            arsc_pkg::B_NUMER: n_state = arsc_pkg::B_DIV;
            arsc_pkg::B_DIV: begin
                if (r_div_cnt == DIVC_W'(DIV_CYCLES - 1)) begin
                    n_state = arsc_pkg::B_PUSH;
                end
            end
            arsc_pkg::B_PUSH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = arsc_pkg::B_IDLE;
                end
            end
            default: n_state = arsc_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            arsc_pkg::B_IDLE: begin
                r_prod <= prod_in;
                r_cur  <= i_job.cur;
                r_last <= i_job.last;
            end
            arsc_pkg::B_SLICE: r_sv <= sv_in;
            arsc_pkg::B_CLAMP: begin
                r_abs <= abs_in;
                r_neg <= neg_in;
            end
            arsc_pkg::B_BOOST: r_mag <= mag_in;
            arsc_pkg::B_NUMER: begin
                r_rem     <= CLIP_W'(numer[NUM_W-1:QUO_W]);
                r_quo     <= numer[QUO_W-1:0];
                r_zero    <= zero_in;
                r_div_cnt <= '0;
            end
            arsc_pkg::B_DIV: begin
                r_rem     <= rem_v[CLIP_W-1:0];
                r_quo     <= quo_v;
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            default: r_rem <= r_rem;
        endcase
    end

endmodule

@@ hw/rtl/arsc_checker.sv @@
// Port-level checks of the audio resample slice scale block, bound to its top level.
`timescale 1ns / 1ps

module arsc_port_checks (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              push,
    input logic                              full,
    input logic                              empty,
    input logic                              pop,
    input logic signed [arsc_pkg::OUT_W-1:0] o_sample_out,
    input logic                              o_last
);

    // Reset leaves no result waiting and the input side open
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // An accepted sample always makes the front busy in the cycle after it
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("front not busy after a transfer in");

    // The front only becomes busy through an accepted sample
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without a transfer in");

    // A waiting result holds until it is transferred
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_sample_out) && $stable(o_last))
        else $error("waiting result changed");

endmodule

bind audio_resample_slice_scale arsc_port_checks u_arsc_port_checks (.*);
